>>> hdl/est_pkg.sv
// Package with shared types and constants for the event subscription table.
`timescale 1ns / 1ps
package est_pkg;
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int CONN_COUNT_DEF = 16;
    localparam int CONTEXT_MAX_DEF = 8;
    localparam int CHANGED_LEVEL_DEF = 1;
    localparam int CHANGED_INDEX_DEF = 1;

    localparam logic [2:0] CMD_ADD_SUB = 3'd0;
    localparam logic [2:0] CMD_ADD_PLAIN = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_DROP = 3'd3;
    localparam logic [2:0] CMD_NOTIFY = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        t_IDLE,
        t_SCAN,
        t_WRITE,
        t_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the request
        logic scan_step; // examine the current slot, advance index
        logic write_new; // write the new entry into the free slot
        logic emit_done; // present the final status item
    } t_ctrl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last; // current slot is the last one
        logic do_write;  // add needs a write after the scan
    } t_stat;
endpackage

>>> hdl/est_ram.sv
// Generic RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module est_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hdl/est_ctrl.sv
// Controller state machine that sequences the table scan of each request.
`timescale 1ns / 1ps
module est_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  est_pkg::t_stat i_stat,
    output est_pkg::t_ctrl o_ctrl,
    output logic          o_busy
);
    est_pkg::t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= est_pkg::t_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            est_pkg::t_IDLE: begin
                if (i_start) n_state = est_pkg::t_SCAN;
            end
            est_pkg::t_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = i_stat.do_write ? est_pkg::t_WRITE : est_pkg::t_DONE;
                end
            end
            est_pkg::t_WRITE: n_state = est_pkg::t_DONE;
            est_pkg::t_DONE:  n_state = est_pkg::t_IDLE;
            default:          n_state = est_pkg::t_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_ctrl = '0;
        o_busy = 1'b1;
        case (r_state)
            est_pkg::t_IDLE: begin
                o_busy = 1'b0;
                o_ctrl.load = i_start;
            end
            est_pkg::t_SCAN:  o_ctrl.scan_step = 1'b1;
            est_pkg::t_WRITE: o_ctrl.write_new = 1'b1;
            est_pkg::t_DONE:  o_ctrl.emit_done = 1'b1;
            default:          o_busy = 1'b1;
        endcase
    end

`ifndef NO_ASSERTIONS
    // A write only follows a scan.
    a_write_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.write_new |-> $past(o_ctrl.scan_step))
        else $error("write without scan");
    // The status item is followed by idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.emit_done |=> !o_busy)
        else $error("no idle after done");
    // A load only happens when idle.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.load |-> !o_busy)
        else $error("load while busy");
`endif
endmodule

>>> hdl/est_dp.sv
// Datapath: request register, entry memories, valid bits, scan and result logic.
`timescale 1ns / 1ps
module est_dp #(
    parameter int TABLE_ENTRIES = est_pkg::TABLE_ENTRIES_DEF,
    parameter int CONN_COUNT = est_pkg::CONN_COUNT_DEF,
    parameter int CONTEXT_MAX = est_pkg::CONTEXT_MAX_DEF,
    parameter int CHANGED_EVENT_LEVEL = est_pkg::CHANGED_LEVEL_DEF,
    parameter int CHANGED_EVENT_INDEX = est_pkg::CHANGED_INDEX_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  est_pkg::t_ctrl i_ctrl,
    output est_pkg::t_stat o_stat,
    input  logic           i_notify_disabled,
    input  logic [2:0]     i_cmd,
    input  logic [3:0]     i_conn_id,
    input  logic           i_conn_valid,
    input  logic [31:0]    i_emitter,
    input  logic [15:0]    i_event_level,
    input  logic [15:0]    i_event_index,
    input  logic [31:0]    i_subscriber_object,
    input  logic [15:0]    i_method_level,
    input  logic [15:0]    i_method_index,
    input  logic [63:0]    i_context_bytes,
    input  logic [15:0]    i_context_length,
    input  logic [7:0]     i_delivery,
    output logic           o_strobe,
    output logic           o_kind,
    output logic [1:0]     o_status,
    output logic [3:0]     o_target_conn,
    output logic [31:0]    o_target_object,
    output logic [15:0]    o_target_method_level,
    output logic [15:0]    o_target_method_index,
    output logic [63:0]    o_ctx_out,
    output logic [3:0]     o_ctx_out_length,
    output logic [15:0]    o_prop_level,
    output logic [15:0]    o_prop_index,
    output logic           o_last
);
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int KEYW = 4 + 32 + 32;
    localparam int PAYW = 64 + 64 + 4 + 8;
    localparam logic [31:0] CHANGED = {CHANGED_EVENT_LEVEL[15:0], CHANGED_EVENT_INDEX[15:0]};
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

    // Request register.
    logic [2:0]  r_cmd;
    logic [3:0]  r_conn;
    logic        r_conn_ok;
    logic [31:0] r_em;
    logic [31:0] r_ev;
    logic [63:0] r_sub;
    logic [63:0] r_ctx;
    logic [3:0]  r_len;
    logic [7:0]  r_dlv;

    // Scan state.
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [AW-1:0] r_idx;        // address presented to the memories
    logic [AW-1:0] r_cur;        // slot whose data is on the read port
    logic          r_cur_ok;     // read data is meaningful
    logic          r_found;
    logic          r_free_ok;
    logic [AW-1:0] r_free;
    logic [1:0]    r_status;

    logic [KEYW-1:0] key_rd;
    logic [PAYW-1:0] pay_rd;
    logic [AW-1:0]   raddr;
    logic            we;

    // Clipped context for the add with subscriber.
    logic [3:0]  clip_len;
    logic [63:0] clip_mask;
    logic        add_cmd;
    always_comb begin
        if (i_context_length > 16'(CONTEXT_MAX)) clip_len = 4'(CONTEXT_MAX);
        else clip_len = i_context_length[3:0];
        clip_mask = '0;
        for (int b = 0; b < 8; b++) begin
            if (b < 32'(clip_len)) clip_mask[63-8*b -: 8] = 8'hFF;
        end
        add_cmd = (i_cmd == est_pkg::CMD_ADD_SUB) || (i_cmd == est_pkg::CMD_ADD_PLAIN);
    end

    // Memories hold key and payload; a write address picks the free slot.
    assign we = i_ctrl.write_new;
    assign raddr = i_ctrl.load ? '0 : r_idx;

    est_ram #(.WIDTH(KEYW), .DEPTH(TABLE_ENTRIES)) u_key (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_free),
        .i_wdata({r_conn, r_em, r_ev}), .i_raddr(raddr), .o_rdata(key_rd));
    est_ram #(.WIDTH(PAYW), .DEPTH(TABLE_ENTRIES)) u_pay (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_free),
        .i_wdata({r_sub, r_ctx, r_len, r_dlv}), .i_raddr(raddr), .o_rdata(pay_rd));

    logic [3:0]  k_conn;
    logic [31:0] k_em;
    logic [31:0] k_ev;
    logic        cur_valid;
    logic        key_match;
    logic        notify_hit;
    logic        scan_end;
    assign {k_conn, k_em, k_ev} = key_rd;
    assign cur_valid = r_valid[r_cur];
    assign key_match = cur_valid && k_conn == r_conn && k_em == r_em && k_ev == r_ev;
    assign notify_hit = r_cur_ok && cur_valid && !i_notify_disabled &&
                        r_cmd == est_pkg::CMD_NOTIFY && k_em == r_em && k_ev == CHANGED;

    function automatic logic key_match_now();
        return r_cur_ok && key_match;
    endfunction
    function automatic logic free_now();
        return r_free_ok || (r_cur_ok && !cur_valid);
    endfunction

    // Scan ends once the last slot's data has been examined.
    assign scan_end = r_cur_ok && r_cur == LAST_IDX;
    assign o_stat.scan_last = scan_end;
    assign o_stat.do_write = (r_cmd == est_pkg::CMD_ADD_SUB || r_cmd == est_pkg::CMD_ADD_PLAIN)
                             && r_conn_ok && !r_found && !key_match_now() && free_now();

    // Request capture, scan bookkeeping and table updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_cur_ok <= 1'b0;
            r_idx <= '0;
            r_cur <= '0;
        end else begin
            if (i_ctrl.load) begin
                r_cmd <= i_cmd;
                r_conn <= i_conn_id;
                r_conn_ok <= i_conn_valid && (32'(i_conn_id) < CONN_COUNT);
                r_em <= i_emitter;
                r_ev <= {i_event_level, i_event_index};
                r_sub <= (i_cmd == est_pkg::CMD_ADD_SUB)
                         ? {i_subscriber_object, i_method_level, i_method_index} : '0;
                r_ctx <= (i_cmd == est_pkg::CMD_ADD_SUB) ? (i_context_bytes & clip_mask) : '0;
                r_len <= (i_cmd == est_pkg::CMD_ADD_SUB) ? clip_len : '0;
                r_dlv <= i_delivery;
                r_idx <= (TABLE_ENTRIES > 1) ? AW'(1) : '0;
                r_cur <= '0;
                r_cur_ok <= 1'b1;
                r_found <= 1'b0;
                r_free_ok <= 1'b0;
                r_status <= (i_cmd > est_pkg::CMD_NOTIFY) ? est_pkg::ST_INVALID
                          : (add_cmd && !(i_conn_valid && (32'(i_conn_id) < CONN_COUNT)))
                            ? est_pkg::ST_INVALID : est_pkg::ST_OK;
            end else if (i_ctrl.scan_step) begin
                if (key_match) r_found <= 1'b1;
                if (!cur_valid && !r_free_ok) begin
                    r_free_ok <= 1'b1;
                    r_free <= r_cur;
                end
                // Remove and drop clear matching slots in place.
                if (r_cmd == est_pkg::CMD_REMOVE && r_conn_ok && key_match)
                    r_valid[r_cur] <= 1'b0;
                if (r_cmd == est_pkg::CMD_DROP && cur_valid && k_conn == r_conn)
                    r_valid[r_cur] <= 1'b0;
                if (scan_end) begin
                    r_cur_ok <= 1'b0;
                    if ((r_cmd == est_pkg::CMD_ADD_SUB || r_cmd == est_pkg::CMD_ADD_PLAIN)
                        && r_conn_ok && !r_found && !key_match && !free_now())
                        r_status <= est_pkg::ST_FULL;
                end else begin
                    r_cur <= r_idx;
                    r_idx <= (r_idx == LAST_IDX) ? r_idx : r_idx + AW'(1);
                end
            end else if (i_ctrl.write_new) begin
                r_valid[r_free] <= 1'b1;
            end
        end
    end

    // Output register: one record per hit, then the status item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= (i_ctrl.scan_step && notify_hit) || i_ctrl.emit_done;
        end
        if (i_ctrl.emit_done) begin
            o_kind <= 1'b0;
            o_status <= r_status;
            o_target_conn <= '0;
            o_target_object <= '0;
            o_target_method_level <= '0;
            o_target_method_index <= '0;
            o_ctx_out <= '0;
            o_ctx_out_length <= '0;
            o_prop_level <= '0;
            o_prop_index <= '0;
            o_last <= 1'b1;
        end else begin
            o_kind <= 1'b1;
            o_status <= est_pkg::ST_OK;
            o_target_conn <= k_conn;
            o_target_object <= pay_rd[PAYW-1 -: 32];
            o_target_method_level <= pay_rd[PAYW-33 -: 16];
            o_target_method_index <= pay_rd[PAYW-49 -: 16];
            o_ctx_out <= pay_rd[75:12];
            o_ctx_out_length <= pay_rd[11:8];
            o_prop_level <= r_ev[31:16];
            o_prop_index <= r_ev[15:0];
            o_last <= 1'b0;
        end
    end

`ifndef NO_ASSERTIONS
    // A write never targets a valid slot.
    a_free_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.write_new |-> !r_valid[r_free])
        else $error("write to valid slot");
    // Table full is only reported when every slot holds a valid entry.
    a_table_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.emit_done && r_status == est_pkg::ST_FULL) |-> (&r_valid))
        else $error("full reported with free slot");
    // Records only appear for notify.
    a_notify_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_kind) |-> r_cmd == est_pkg::CMD_NOTIFY)
        else $error("record outside notify");
`endif
endmodule

>>> hdl/event_subscription_table_top.sv
// Top level of the event subscription table.
`timescale 1ns / 1ps
// Usage:
// A request is taken at a rising edge where start is high and busy low;
// its fields sit on the i_ ports. The block scans all TABLE_ENTRIES slots,
// one slot per cycle from the registered read of the entry memory.
// Notify gives one record (o_kind 1) per matching slot, in slot order, while
// the scan runs; every request ends with one status item (o_kind 0, o_last 1).
// Each result is shown for one cycle with o_strobe high; the receiver cannot
// stall, so results are never held.
// A request passes the states SCAN, then WRITE for an add that stores a new
// entry, then DONE; busy is low again in the same cycle that carries the
// status item. The scan length is set by the single read port.
// i_notify_disabled_we with i_notify_disabled_wdata writes the notify disable
// register; write it only while idle.
// Synchronous reset clears all valid bits and the register; no clearing pass.
module event_subscription_table_top #(
    parameter int TABLE_ENTRIES = est_pkg::TABLE_ENTRIES_DEF,
    parameter int CONN_COUNT = est_pkg::CONN_COUNT_DEF,
    parameter int CONTEXT_MAX = est_pkg::CONTEXT_MAX_DEF,
    parameter int CHANGED_EVENT_LEVEL = est_pkg::CHANGED_LEVEL_DEF,
    parameter int CHANGED_EVENT_INDEX = est_pkg::CHANGED_INDEX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_notify_disabled_we,
    input  logic        i_notify_disabled_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [3:0]  i_conn_id,
    input  logic        i_conn_valid,
    input  logic [31:0] i_emitter,
    input  logic [15:0] i_event_level,
    input  logic [15:0] i_event_index,
    input  logic [31:0] i_subscriber_object,
    input  logic [15:0] i_method_level,
    input  logic [15:0] i_method_index,
    input  logic [63:0] i_context_bytes,
    input  logic [15:0] i_context_length,
    input  logic [7:0]  i_delivery,
    output logic        o_strobe,
    output logic        o_kind,
    output logic [1:0]  o_status,
    output logic [3:0]  o_target_conn,
    output logic [31:0] o_target_object,
    output logic [15:0] o_target_method_level,
    output logic [15:0] o_target_method_index,
    output logic [63:0] o_ctx_out,
    output logic [3:0]  o_ctx_out_length,
    output logic [15:0] o_prop_level,
    output logic [15:0] o_prop_index,
    output logic        o_last
);
    est_pkg::t_ctrl ctrl;
    est_pkg::t_stat stat;
    logic r_notify_disabled;

    // Notify disable register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_notify_disabled <= 1'b0;
        end else if (i_notify_disabled_we) begin
            r_notify_disabled <= i_notify_disabled_wdata;
        end
    end

    est_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_stat(stat), .o_ctrl(ctrl), .o_busy(busy));

    est_dp #(
        .TABLE_ENTRIES(TABLE_ENTRIES), .CONN_COUNT(CONN_COUNT),
        .CONTEXT_MAX(CONTEXT_MAX), .CHANGED_EVENT_LEVEL(CHANGED_EVENT_LEVEL),
        .CHANGED_EVENT_INDEX(CHANGED_EVENT_INDEX)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl), .o_stat(stat),
        .i_notify_disabled(r_notify_disabled),
        .i_cmd(i_cmd), .i_conn_id(i_conn_id), .i_conn_valid(i_conn_valid),
        .i_emitter(i_emitter), .i_event_level(i_event_level),
        .i_event_index(i_event_index), .i_subscriber_object(i_subscriber_object),
        .i_method_level(i_method_level), .i_method_index(i_method_index),
        .i_context_bytes(i_context_bytes), .i_context_length(i_context_length),
        .i_delivery(i_delivery),
        .o_strobe(o_strobe), .o_kind(o_kind), .o_status(o_status),
        .o_target_conn(o_target_conn), .o_target_object(o_target_object),
        .o_target_method_level(o_target_method_level),
        .o_target_method_index(o_target_method_index),
        .o_ctx_out(o_ctx_out), .o_ctx_out_length(o_ctx_out_length),
        .o_prop_level(o_prop_level), .o_prop_index(o_prop_index), .o_last(o_last));
endmodule
